// File: rtl/core/npc_pkg.sv
// Shared constants and types for the nearest palette color search.
`timescale 1ns / 1ps
package npc_pkg;

  localparam int PAL_DEPTH    = 256;
  localparam int IDX_W        = $clog2(PAL_DEPTH);
  localparam int CH_W         = 8;
  localparam int CFG_W        = 9;
  localparam int PIX_IDX_W    = 8;
  localparam int ENTRY_W      = 3 * CH_W;
  localparam int SQ_W         = 2 * CH_W;
  localparam int CH_LEVELS    = 1 << CH_W;
  localparam int START_BOUND  = 3 * (CH_LEVELS * CH_LEVELS);
  localparam int DIST_W       = $clog2(START_BOUND + 1);
  localparam int CFG_RESET    = 256;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_MAP   = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_HOLD
  } npc_state_t;

  typedef struct packed {
    logic wr;
    logic start;
    logic run;
    logic load;
  } npc_cmd_t;

  typedef struct packed {
    logic done;
  } npc_sts_t;

endpackage

// File: rtl/core/nearest_palette_color_top.sv
// Top level of the nearest palette color search: controller plus datapath.
// A write beat leaves the controller idle; the next beat is accepted in the following cycle.
// A map beat scans N = min(palette_count, 256) entries, reading the palette RAM one entry per
// cycle, then raises out_valid; an exact match at entry j ends the scan as if N were j + 1.
// The next beat can be accepted in the cycle in which out_valid rises; while the output
// register is still full, a finished result waits in the HOLD state.
// Synchronous active-low reset sets palette_count to 256; palette contents are undefined.
`timescale 1ns / 1ps
module nearest_palette_color_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [npc_pkg::PIX_IDX_W-1:0]     in_entry_index,
  input  logic [npc_pkg::CH_W-1:0]          in_red,
  input  logic [npc_pkg::CH_W-1:0]          in_green,
  input  logic [npc_pkg::CH_W-1:0]          in_blue,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [npc_pkg::PIX_IDX_W-1:0]     out_palette_index,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [npc_pkg::CFG_W-1:0]         cfg_palette_count
);
  import npc_pkg::*;

  npc_cmd_t cmd;
  npc_sts_t sts;

  assign cfg_ready = 1'b1;

  npc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  npc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_palette_count (cfg_palette_count),
    .in_entry_index    (in_entry_index),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_palette_index (out_palette_index),
    .sts               (sts)
  );

endmodule

// File: rtl/core/npc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module npc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/npc_ctrl.sv
// Controller state machine for write and map beats and the result register.
`timescale 1ns / 1ps
module npc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_operation,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  npc_pkg::npc_sts_t sts,
  output npc_pkg::npc_cmd_t cmd
);
  import npc_pkg::*;

  npc_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;
  logic       accept;

  assign slot_free = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_operation == OP_MAP) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts.done) begin
          state_nxt = slot_free ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.wr    = accept && in_operation == OP_WRITE;
        cmd.start = accept && in_operation == OP_MAP;
      end
      S_SEARCH: begin
        cmd.run  = 1'b1;
        cmd.load = sts.done && slot_free;
      end
      S_HOLD: begin
        cmd.load = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/npc_dp.sv
// Datapath: palette store, count register, distance pipeline and best tracker.
`timescale 1ns / 1ps
module npc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  npc_pkg::npc_cmd_t                 cmd,
  input  logic                              cfg_we,
  input  logic [npc_pkg::CFG_W-1:0]         cfg_palette_count,
  input  logic [npc_pkg::PIX_IDX_W-1:0]     in_entry_index,
  input  logic [npc_pkg::CH_W-1:0]          in_red,
  input  logic [npc_pkg::CH_W-1:0]          in_green,
  input  logic [npc_pkg::CH_W-1:0]          in_blue,
  output logic [npc_pkg::PIX_IDX_W-1:0]     out_palette_index,
  output npc_pkg::npc_sts_t                 sts
);
  import npc_pkg::*;

  logic [CFG_W-1:0]     count_r;
  logic [CFG_W-1:0]     lim_r;
  logic [CFG_W-1:0]     lim_nxt;
  logic [CFG_W-1:0]     rd_cnt_r;
  logic [CH_W-1:0]      red_r, green_r, blue_r;
  logic                 issue;
  logic                 ram_we;
  logic [ENTRY_W-1:0]   rdata;

  logic                 v1_r, v2_r, found_r;
  logic [IDX_W-1:0]     idx1_r, idx2_r;
  logic [SQ_W-1:0]      sq_r [3];
  logic [SQ_W-1:0]      sq_nxt [3];
  logic [CH_W-1:0]      ent_ch [3];
  logic [CH_W-1:0]      pix_ch [3];
  logic [CH_W-1:0]      diff [3];
  logic [DIST_W-1:0]    dist_sum;
  logic [DIST_W-1:0]    best_r;
  logic [IDX_W-1:0]     best_pos_r;
  logic [PIX_IDX_W-1:0] out_idx_r;
  logic                 better;

  assign ram_we = cmd.wr && ({1'b0, in_entry_index} < CFG_W'(PAL_DEPTH));

  assign issue = cmd.run && !found_r && (rd_cnt_r < lim_r);

  npc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PAL_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_entry_index[IDX_W-1:0]),
    .wdata ({in_red, in_green, in_blue}),
    .re    (issue),
    .raddr (rd_cnt_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  assign lim_nxt = (count_r > CFG_W'(PAL_DEPTH)) ? CFG_W'(PAL_DEPTH) : count_r;

  assign ent_ch[0] = rdata[ENTRY_W-1 -: CH_W];
  assign ent_ch[1] = rdata[2*CH_W-1 -: CH_W];
  assign ent_ch[2] = rdata[CH_W-1:0];
  assign pix_ch[0] = red_r;
  assign pix_ch[1] = green_r;
  assign pix_ch[2] = blue_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]   = (ent_ch[k] > pix_ch[k]) ? (ent_ch[k] - pix_ch[k]) : (pix_ch[k] - ent_ch[k]);
      sq_nxt[k] = SQ_W'(diff[k]) * SQ_W'(diff[k]);
    end
  end

  assign dist_sum = DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);
  assign better   = v2_r && !found_r && (dist_sum < best_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= CFG_W'(CFG_RESET);
      rd_cnt_r <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_palette_count;
      end
      if (cmd.start) begin
        rd_cnt_r <= '0;
        v1_r     <= 1'b0;
        v2_r     <= 1'b0;
        found_r  <= 1'b0;
      end else begin
        if (issue) begin
          rd_cnt_r <= rd_cnt_r + 1'b1;
        end
        v1_r <= issue;
        v2_r <= v1_r;
        if (better && dist_sum == '0) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      red_r      <= in_red;
      green_r    <= in_green;
      blue_r     <= in_blue;
      lim_r      <= lim_nxt;
      best_r     <= DIST_W'(START_BOUND);
      best_pos_r <= '0;
    end else if (better) begin
      best_r     <= dist_sum;
      best_pos_r <= idx2_r;
    end
    idx1_r <= rd_cnt_r[IDX_W-1:0];
    idx2_r <= idx1_r;
    for (int k = 0; k < 3; k++) begin
      sq_r[k] <= sq_nxt[k];
    end
    if (cmd.load) begin
      out_idx_r <= PIX_IDX_W'(best_pos_r);
    end
  end

  assign sts.done = cmd.run && (found_r || (rd_cnt_r >= lim_r && !v1_r && !v2_r));
  assign out_palette_index = out_idx_r;

endmodule
